FILE: rtl/rmm2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmm2d_pkg;

	// Counts and indices up to 1024 rows or columns
	localparam int CNT_W = 11;
	// Table levels up to 10
	localparam int LVL_W = 4;

	// Configuration register indexes
	localparam logic [1:0] CFG_MODE = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;
	localparam logic [1:0] CFG_COLS = 2'd2;

	// Request kinds
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B_CHK,
		ST_B_RA,
		ST_B_RB,
		ST_B_WR,
		ST_B_ADV,
		ST_Q_PREP,
		ST_Q_A,
		ST_Q_B,
		ST_Q_C,
		ST_Q_D,
		ST_Q_E,
		ST_Q_OUT
	} state_t;

	// floor(log2(v)), zero for v of zero or one
	function automatic logic [LVL_W-1:0] flog2(input logic [CNT_W-1:0] v);
		logic [LVL_W-1:0] r;
		r = '0;
		for (int b = 1; b < CNT_W; b++) begin
			if (v[b]) begin
				r = LVL_W'(b);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/rmm2d_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rmm2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire  [WIDTH-1:0]                     wdata,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

FILE: rtl/range_min_max_2d_sparse_table.sv
// Load request: written to the store at acceptance if in range; loads can follow back to back.
// Query request: result after four reads of one single-port store (states Q_PREP, Q_A to Q_E, Q_OUT);
// the next request is taken once the result is registered for output; an invalid query goes straight
// to Q_OUT for its error result. A result left waiting on the output holds the next one.
// Build after the last cell, no request taken: each row/column/level sequencer step passes B_CHK, B_ADV;
// each table entry written also passes B_RA, B_RB and B_WR. Reset sets only the control registers.
`timescale 1ns / 1ps
`default_nettype none
module range_min_max_2d_sparse_table
	import rmm2d_pkg::*;
#(
	parameter int MAX_ROWS   = 32,
	parameter int MAX_COLS   = 32,
	parameter int DATA_WIDTH = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// load_row[4:0], load_col[9:5], cell_value[41:10], query_row_low[46:42],
	// query_row_high[51:47], query_col_low[56:52], query_col_high[61:57], zero[63:62]
	input  wire  [63:0] s_tdata,
	// action[0]
	input  wire         s_tuser,
	// last_cell
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	// range_result[31:0]
	output logic [31:0] m_tdata,
	// range_error[0]
	output logic        m_tuser,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [5:0]  cfg_data
);

	localparam int LR    = $clog2(MAX_ROWS + 1);
	localparam int LC    = $clog2(MAX_COLS + 1);
	localparam int DEPTH = MAX_ROWS * MAX_COLS * LR * LC;
	localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

	function automatic logic [AW-1:0] slot(input logic [CNT_W-1:0] i, input logic [CNT_W-1:0] j,
		input logic [LVL_W-1:0] k, input logic [LVL_W-1:0] l);
		logic [31:0] t;
		t = ((32'(i) * 32'(MAX_COLS) + 32'(j)) * 32'(LR) + 32'(k)) * 32'(LC) + 32'(l);
		return AW'(t);
	endfunction

	function automatic logic [DATA_WIDTH-1:0] pick(input logic mode,
		input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b);
		logic a_gt;
		a_gt = $signed(a) > $signed(b);
		return (mode ? a_gt : !a_gt) ? a : b;
	endfunction

	// Registers
	logic             mode_q;
	logic [5:0]       rows_q, cols_q;
	state_t           state_q, state_d;
	logic [CNT_W-1:0] bi_q, bj_q;
	logic [LVL_W-1:0] bk_q, bl_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic             err_q;
	logic [CNT_W-1:0] r1_q, r2_q, c1_q, c2_q, rb_q, cb_q;
	logic [LVL_W-1:0] rl_q, cl_q;
	logic             m_valid_q;
	logic [31:0]      m_data_q;
	logic             m_err_q;

	// RAM port
	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

	rmm2d_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Request fields
	logic [4:0]  in_row, in_col, in_r1, in_r2, in_c1, in_c2;
	logic [31:0] in_val;
	assign in_row = s_tdata[4:0];
	assign in_col = s_tdata[9:5];
	assign in_val = s_tdata[41:10];
	assign in_r1  = s_tdata[46:42];
	assign in_r2  = s_tdata[51:47];
	assign in_c1  = s_tdata[56:52];
	assign in_c2  = s_tdata[61:57];

	// Effective grid size
	logic [CNT_W-1:0] n_eff, m_eff;
	assign n_eff = (CNT_W'(rows_q) > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : CNT_W'(rows_q);
	assign m_eff = (CNT_W'(cols_q) > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(cols_q);

	logic s_acc, is_load, load_in, q_bad;
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign is_load  = (s_tuser == ACT_LOAD);
	assign load_in  = (CNT_W'(in_row) < CNT_W'(MAX_ROWS)) && (CNT_W'(in_col) < CNT_W'(MAX_COLS));
	assign q_bad    = (in_r1 > in_r2) || (in_c1 > in_c2) ||
		(CNT_W'(in_r2) >= n_eff) || (CNT_W'(in_c2) >= m_eff);

	// Build sequencer levels for current cell
	logic [LVL_W-1:0] kr, lc;
	logic             b_valid, b_last;
	assign kr      = flog2(n_eff - bi_q);
	assign lc      = flog2(m_eff - bj_q);
	assign b_valid = (bl_q <= lc) && ((bk_q != '0) || (bl_q != '0));
	assign b_last  = (bl_q >= lc) && (bk_q >= kr) && (bi_q == '0) && (bj_q == '0);

	// Build read addresses
	logic [LVL_W-1:0] bk_m1, bl_m1;
	logic [AW-1:0]    b_addr_a, b_addr_b;
	assign bk_m1 = bk_q - LVL_W'(1);
	assign bl_m1 = bl_q - LVL_W'(1);
	always_comb begin
		if (bl_q == '0) begin
			b_addr_a = slot(bi_q, bj_q, bk_m1, '0);
			b_addr_b = slot(bi_q + (CNT_W'(1) << bk_m1), bj_q, bk_m1, '0);
		end else begin
			b_addr_a = slot(bi_q, bj_q, bk_q, bl_m1);
			b_addr_b = slot(bi_q, bj_q + (CNT_W'(1) << bl_m1), bk_q, bl_m1);
		end
	end

	logic out_free;
	assign out_free = !m_valid_q || m_tready;

	// Next state and store port
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = slot(CNT_W'(in_row), CNT_W'(in_col), '0, '0);
		ram_wdata = DATA_WIDTH'($signed(in_val));
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					if (is_load) begin
						ram_we = load_in;
						if (s_tlast && n_eff != '0 && m_eff != '0) begin
							state_d = ST_B_CHK;
						end
					end else begin
						state_d = q_bad ? ST_Q_OUT : ST_Q_PREP;
					end
				end
			end
			ST_B_CHK: state_d = b_valid ? ST_B_RA : ST_B_ADV;
			ST_B_RA: begin
				ram_addr = b_addr_a;
				state_d  = ST_B_RB;
			end
			ST_B_RB: begin
				ram_addr = b_addr_b;
				state_d  = ST_B_WR;
			end
			ST_B_WR: begin
				ram_we    = 1'b1;
				ram_addr  = slot(bi_q, bj_q, bk_q, bl_q);
				ram_wdata = pick(mode_q, acc_q, ram_rdata);
				state_d   = ST_B_ADV;
			end
			ST_B_ADV: state_d = b_last ? ST_IDLE : ST_B_CHK;
			ST_Q_PREP: state_d = ST_Q_A;
			ST_Q_A: begin
				ram_addr = slot(r1_q, c1_q, rl_q, cl_q);
				state_d  = ST_Q_B;
			end
			ST_Q_B: begin
				ram_addr = slot(rb_q, c1_q, rl_q, cl_q);
				state_d  = ST_Q_C;
			end
			ST_Q_C: begin
				ram_addr = slot(r1_q, cb_q, rl_q, cl_q);
				state_d  = ST_Q_D;
			end
			ST_Q_D: begin
				ram_addr = slot(rb_q, cb_q, rl_q, cl_q);
				state_d  = ST_Q_E;
			end
			ST_Q_E: state_d = ST_Q_OUT;
			ST_Q_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= 1'b0;
			rows_q    <= 6'd32;
			cols_q    <= 6'd32;
			m_valid_q <= 1'b0;
			bi_q      <= '0;
			bj_q      <= '0;
			bk_q      <= '0;
			bl_q      <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[0];
					CFG_ROWS: rows_q <= cfg_data;
					CFG_COLS: cols_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_Q_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			// build counters
			if (state_q == ST_IDLE) begin
				bi_q <= n_eff - CNT_W'(1);
				bj_q <= m_eff - CNT_W'(1);
				bk_q <= '0;
				bl_q <= '0;
			end else if (state_q == ST_B_ADV) begin
				if (bl_q < lc) begin
					bl_q <= bl_q + LVL_W'(1);
				end else if (bk_q < kr) begin
					bk_q <= bk_q + LVL_W'(1);
					bl_q <= '0;
				end else begin
					bk_q <= '0;
					bl_q <= '0;
					if (bj_q == '0) begin
						bj_q <= m_eff - CNT_W'(1);
						bi_q <= bi_q - CNT_W'(1);
					end else begin
						bj_q <= bj_q - CNT_W'(1);
					end
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			r1_q  <= CNT_W'(in_r1);
			r2_q  <= CNT_W'(in_r2);
			c1_q  <= CNT_W'(in_c1);
			c2_q  <= CNT_W'(in_c2);
			err_q <= q_bad;
			acc_q <= '0;
		end
		unique case (state_q)
			ST_B_RB: acc_q <= ram_rdata;
			ST_Q_PREP: begin
				rl_q <= flog2(r2_q - r1_q + CNT_W'(1));
				cl_q <= flog2(c2_q - c1_q + CNT_W'(1));
			end
			ST_Q_A: begin
				rb_q <= r2_q + CNT_W'(1) - (CNT_W'(1) << rl_q);
				cb_q <= c2_q + CNT_W'(1) - (CNT_W'(1) << cl_q);
			end
			ST_Q_B: acc_q <= ram_rdata;
			ST_Q_C, ST_Q_D, ST_Q_E: acc_q <= pick(mode_q, acc_q, ram_rdata);
			default: ;
		endcase
		if (state_q == ST_Q_OUT && out_free) begin
			m_data_q <= 32'($signed(acc_q));
			m_err_q  <= err_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_err_q;

endmodule
`default_nettype wire
